// File: hw/rtl/ialu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and constants for the six-operation integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned ProdW  = 2 * DataW;
  localparam int unsigned CntW   = $clog2(DataW);
  localparam int unsigned InTdW  = 72;
  localparam int unsigned OutTdW = 40;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_REM = 3'd4,
    CMD_POW = 3'd5
  } cmd_t;

  localparam logic [StatW-1:0] STAT_OK   = 2'd0;
  localparam logic [StatW-1:0] STAT_DIVZ = 2'd1;
  localparam logic [StatW-1:0] STAT_OVF  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MULR,
    ST_PA,
    ST_PB,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] rem;
  } div_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/ialu_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_mul
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module ialu_mul
  import ialu_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [DataW-1:0] x,
  input  wire logic signed [DataW-1:0] y,
  output logic signed [ProdW-1:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= x * y;
  end

endmodule
`default_nettype wire

// File: hw/rtl/ialu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_div
// Restoring bit-serial signed divider: one quotient bit per cycle, then a
// sign fix step. The quotient truncates; the remainder follows the dividend.
// ----------------------------------------------------------------------------
module ialu_div
  import ialu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DataW-1:0] dividend,
  input  wire logic [DataW-1:0] divisor,
  output div_res_t              res
);

  logic             busy;
  logic             fix;
  logic [CntW-1:0]  cnt;
  logic [DataW-1:0] quo;
  logic [DataW-1:0] rem;
  logic [DataW-1:0] dvs;
  logic             neg_q;
  logic             neg_r;
  logic [DataW:0]   sh;
  logic [DataW:0]   diff;
  logic             ge;

  assign sh   = {rem, quo[DataW-1]};
  assign diff = sh - {1'b0, dvs};
  assign ge   = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fix      <= 1'b0;
      res.done <= 1'b0;
      cnt      <= '0;
    end else begin
      res.done <= fix;
      fix      <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DataW - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end
      if (fix) begin
        res.quo <= neg_q ? (~quo + 1'b1) : quo;
        res.rem <= neg_r ? (~rem + 1'b1) : rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[DataW-1] ? (~dividend + 1'b1) : dividend;
      dvs   <= divisor[DataW-1] ? (~divisor + 1'b1) : divisor;
      rem   <= '0;
      neg_q <= dividend[DataW-1] ^ divisor[DataW-1];
      neg_r <= dividend[DataW-1];
    end else if (busy) begin
      rem <= ge ? diff[DataW-1:0] : sh[DataW-1:0];
      quo <= {quo[DataW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/integer_alu_six_ops.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_six_ops
// Signed 32-bit ALU: add, subtract, multiply, divide, remainder and power,
// with a status code per result.
//
//   Channel   Direction  Transaction contents
//   s_axis    in         command [2:0], operand_a [34:3], operand_b [66:35]
//   m_axis    out        value [31:0], status [33:32]
//
// Add, subtract and the special cases go from the input straight to ST_FIN.
// Multiply passes through ST_MUL and ST_MULR on the shared multiplier. Divide
// and remainder wait in ST_DIV on the one-bit-per-cycle divider. Power runs
// ST_PA and ST_PB once per exponent bit up to its highest set bit, on the
// multiplier that alternates between the accumulate and the square.
// One transaction is in work at a time; the output register lets the next
// transaction be taken while a result waits. Reset is synchronous.
// ----------------------------------------------------------------------------
module integer_alu_six_ops
  import ialu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [InTdW-1:0]  s_tdata,  // command, operand_a, operand_b
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OutTdW-1:0]      m_tdata   // value, status
);

  localparam logic [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] OneVal = DataW'(1);
  localparam logic [DataW-1:0] AllOne = '1;

  state_t            state, state_next;
  logic [CmdW-1:0]   cmd, cmd_next;
  logic [DataW-1:0]  acc, acc_next;
  logic [DataW-1:0]  sq, sq_next;
  logic [DataW-2:0]  ex, ex_next;
  logic              ovf, ovf_next;
  logic              sq_big, sq_big_next;
  logic              first, first_next;
  logic [DataW-1:0]  res_val, res_val_next;
  logic [StatW-1:0]  res_st, res_st_next;
  logic              m_tvalid_next;
  logic [DataW-1:0]  m_val, m_val_next;
  logic [StatW-1:0]  m_st, m_st_next;

  logic [CmdW-1:0]   in_cmd;
  logic [DataW-1:0]  in_a;
  logic [DataW-1:0]  in_b;
  logic              accept;
  logic              div_start;
  logic [DataW-1:0]  mul_x;
  logic [DataW-1:0]  mul_y;
  logic [ProdW-1:0]  prod;
  logic              prod_fits;
  div_res_t          div_res;

  assign in_cmd = s_tdata[CmdW-1:0];
  assign in_a   = s_tdata[CmdW+DataW-1:CmdW];
  assign in_b   = s_tdata[CmdW+2*DataW-1:CmdW+DataW];
  assign accept = s_tvalid && s_tready;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(OutTdW-DataW-StatW){1'b0}}, m_st, m_val};

  assign mul_x = (state == ST_PB) ? sq : acc;
  assign mul_y = (state == ST_PA && !first) ? prod[DataW-1:0] : sq;
  assign prod_fits = (prod[ProdW-1:DataW-1] == '0) || (prod[ProdW-1:DataW-1] == '1);

  ialu_mul u_mul (
    .clk  (clk),
    .x    (mul_x),
    .y    (mul_y),
    .prod (prod)
  );

  ialu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_a),
    .divisor  (in_b),
    .res      (div_res)
  );

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    acc_next      = acc;
    sq_next       = sq;
    ex_next       = ex;
    ovf_next      = ovf;
    sq_big_next   = sq_big;
    first_next    = first;
    res_val_next  = res_val;
    res_st_next   = res_st;
    m_tvalid_next = m_tvalid && !m_tready;
    m_val_next    = m_val;
    m_st_next     = m_st;
    div_start     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_next     = in_cmd;
          res_val_next = '0;
          res_st_next  = STAT_OK;
          state_next   = ST_FIN;
          case (in_cmd)
            CMD_ADD: res_val_next = in_a + in_b;
            CMD_SUB: res_val_next = in_a - in_b;
            CMD_MUL: begin
              acc_next   = in_a;
              sq_next    = in_b;
              state_next = ST_MUL;
            end
            CMD_DIV, CMD_REM: begin
              if (in_b == '0) begin
                res_st_next = STAT_DIVZ;
              end else if (in_cmd == CMD_DIV && in_a == MinVal && in_b == AllOne) begin
                res_val_next = MinVal;
                res_st_next  = STAT_OVF;
              end else begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end
            end
            CMD_POW: begin
              if (in_b[DataW-1]) begin
                if (in_a == '0) begin
                  res_st_next = STAT_DIVZ;
                end else if (in_a == OneVal) begin
                  res_val_next = OneVal;
                end else if (in_a == AllOne) begin
                  res_val_next = in_b[0] ? AllOne : OneVal;
                end
              end else if (in_b == '0) begin
                res_val_next = OneVal;
              end else begin
                acc_next    = OneVal;
                sq_next     = in_a;
                ex_next     = in_b[DataW-2:0];
                ovf_next    = 1'b0;
                sq_big_next = 1'b0;
                first_next  = 1'b1;
                state_next  = ST_PA;
              end
            end
            default: res_val_next = '0;
          endcase
        end
      end
      ST_MUL: state_next = ST_MULR;
      ST_MULR: begin
        res_val_next = prod[DataW-1:0];
        res_st_next  = STAT_OK;
        state_next   = ST_FIN;
      end
      ST_PA: begin
        if (!first) begin
          sq_next     = prod[DataW-1:0];
          sq_big_next = sq_big || !prod_fits;
        end
        first_next = 1'b0;
        state_next = ST_PB;
      end
      ST_PB: begin
        if (ex[0]) begin
          acc_next = prod[DataW-1:0];
          ovf_next = ovf || sq_big || !prod_fits;
        end
        ex_next = ex >> 1;
        if (ex[DataW-2:1] == '0) begin
          res_val_next = acc_next;
          res_st_next  = ovf_next ? STAT_OVF : STAT_OK;
          state_next   = ST_FIN;
        end else begin
          state_next = ST_PA;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          res_val_next = (cmd == CMD_DIV) ? div_res.quo : div_res.rem;
          res_st_next  = STAT_OK;
          state_next   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_val_next    = res_val;
          m_st_next     = res_st;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    acc     <= acc_next;
    sq      <= sq_next;
    ex      <= ex_next;
    ovf     <= ovf_next;
    sq_big  <= sq_big_next;
    first   <= first_next;
    res_val <= res_val_next;
    res_st  <= res_st_next;
    m_val   <= m_val_next;
    m_st    <= m_st_next;
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("Sequencer stayed idle after taking a transaction.");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("Divider finished outside the divide state.");

  a_pow_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_PB |=> state == ST_PA || state == ST_FIN)
    else $error("Power step left the square-and-multiply loop.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_st != 2'd3)
    else $error("Output status holds an unused code.");

endmodule
`default_nettype wire
